FILE: design/spq_pkg.sv
// shared types, codes and defaults for the sorted priority queue
`default_nettype none
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_DUP   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // one queue entry
    typedef struct packed {
        logic [15:0] key;
        logic [15:0] prio;
        logic [31:0] tag;
    } entry_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic   scan;
        logic   insert;
        logic   remove;
        entry_t item;
    } cell_ctl_t;

endpackage
`default_nettype wire

FILE: design/spq_in_if.sv
// command channel: valid, ready and the command beat
`default_nettype none
interface spq_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] unique_key;
    logic [15:0] priority_req;
    logic [31:0] payload_tag;

    modport source (output valid, output cmd, output unique_key, output priority_req,
                    output payload_tag, input ready);
    modport sink (input valid, input cmd, input unique_key, input priority_req,
                  input payload_tag, output ready);
endinterface
`default_nettype wire

FILE: design/spq_out_if.sv
// result channel: valid, ready and the result beat
`default_nettype none
interface spq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_key;
    logic [15:0] out_priority;
    logic [31:0] out_payload;
    logic [15:0] head_key;
    logic [15:0] head_priority;
    logic [4:0]  occupancy;

    modport source (output valid, output status, output out_key, output out_priority,
                    output out_payload, output head_key, output head_priority,
                    output occupancy, input ready);
    modport sink (input valid, input status, input out_key, input out_priority,
                  input out_payload, input head_key, input head_priority,
                  input occupancy, output ready);
endinterface
`default_nettype wire

FILE: design/spq_cell.sv
// one queue cell: holds an entry, shifts with its neighbors, ripples the key match
`default_nettype none
module spq_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spq_pkg::cell_ctl_t ctl,
    input  wire spq_pkg::entry_t   left_entry,
    input  wire logic              left_valid,
    input  wire logic              left_stay,
    input  wire logic              left_any,
    input  wire spq_pkg::entry_t   right_entry,
    input  wire logic              right_valid,
    output spq_pkg::entry_t        entry,
    output logic                   valid,
    output logic                   stay,
    output logic                   any
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            valid_reg;
    logic            valid_next;
    logic            any_reg;
    logic            any_next;

    // this entry stays put on insert: it sorts at or before the new one
    assign stay = valid_reg && (entry_reg.prio <= ctl.item.prio);

    // shift decision
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.insert)
        begin
            if (!stay)
            begin
                if (left_stay)
                begin
                    entry_next = ctl.item;
                    valid_next = 1'b1;
                end
                else
                begin
                    entry_next = left_entry;
                    valid_next = left_valid;
                end
            end
        end
        else if (ctl.remove)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    // key match ripples one cell per cycle toward the tail
    assign any_next = ctl.scan &&
                      (left_any || (valid_reg && (entry_reg.key == ctl.item.key)));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            any_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            any_reg   <= any_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign any   = any_reg;

endmodule
`default_nettype wire

FILE: design/sorted_priority_queue_unique_key_top.sv
// Sorted priority queue with unique keys, built as a row of shifting cells.
// Remove, and insert into a full queue: the sequencer goes from idle straight to apply.
// Other inserts: the sequencer scans while the key match ripples through the cell row.
// One command at a time; the next is accepted the cycle after the result is registered.
// Reset (async, active low) empties the queue; entry contents are left as they were.
`default_nettype none
module sorted_priority_queue_unique_key_top #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);

    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int SCW  = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [SCW-1:0]  scan_cnt_reg;
    logic [SCW-1:0]  scan_cnt_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            cmd_reg;
    spq_pkg::entry_t item_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    spq_pkg::entry_t removed_reg;
    spq_pkg::entry_t removed_next;
    logic [15:0]     head_key_reg;
    logic [15:0]     head_key_next;
    logic [15:0]     head_prio_reg;
    logic [15:0]     head_prio_next;
    logic [4:0]      occ_reg;
    logic [CNTW+4:0] count_ext;

    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_stay;
    logic [QUEUE_DEPTH-1:0] cell_any;

    logic accept;
    logic full;
    logic empty;
    logic dup;
    logic slot_free;
    logic apply_go;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign full      = (count_reg == CNTW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign dup       = cell_any[QUEUE_DEPTH-1];
    assign slot_free = !out_valid_reg || rsp.ready;
    assign apply_go  = (state_reg == S_APPLY) && slot_free;

    // broadcast control to the cell row; the match keeps rippling while the
    // result waits for the output slot, and clears once back in idle
    always_comb
    begin
        ctl.scan   = (state_reg == S_SCAN) || (state_reg == S_APPLY);
        ctl.insert = apply_go && (cmd_reg == spq_pkg::CMD_INSERT) && !full && !dup;
        ctl.remove = apply_go && (cmd_reg == spq_pkg::CMD_REMOVE) && !empty;
        ctl.item   = item_reg;
    end

    // cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t l_entry;
        logic            l_valid;
        logic            l_stay;
        logic            l_any;
        spq_pkg::entry_t r_entry;
        logic            r_valid;

        if (i == 0)
        begin : g_first
            assign l_entry = '0;
            assign l_valid = 1'b0;
            assign l_stay  = 1'b1;
            assign l_any   = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_entry = cell_entry[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_stay  = cell_stay[i-1];
            assign l_any   = cell_any[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign r_entry = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_entry = cell_entry[i+1];
            assign r_valid = cell_valid[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_entry  (l_entry),
            .left_valid  (l_valid),
            .left_stay   (l_stay),
            .left_any    (l_any),
            .right_entry (r_entry),
            .right_valid (r_valid),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .stay        (cell_stay[i]),
            .any         (cell_any[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                scan_cnt_next = '0;
                if (accept)
                begin
                    if ((req.cmd == spq_pkg::CMD_INSERT) && !full)
                        state_next = S_SCAN;
                    else
                        state_next = S_APPLY;
                end
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCW'(QUEUE_DEPTH - 1))
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result of the command being applied
    always_comb
    begin
        count_next     = count_reg;
        status_next    = spq_pkg::ST_OK;
        removed_next   = '0;
        head_key_next  = cell_valid[0] ? cell_entry[0].key  : 16'd0;
        head_prio_next = cell_valid[0] ? cell_entry[0].prio : 16'd0;
        if (cmd_reg == spq_pkg::CMD_INSERT)
        begin
            if (full)
                status_next = spq_pkg::ST_FULL;
            else if (dup)
                status_next = spq_pkg::ST_DUP;
            else
            begin
                count_next = count_reg + 1'b1;
                if (!cell_stay[0])
                begin
                    head_key_next  = item_reg.key;
                    head_prio_next = item_reg.prio;
                end
            end
        end
        else
        begin
            if (empty)
                status_next = spq_pkg::ST_EMPTY;
            else
            begin
                count_next     = count_reg - 1'b1;
                removed_next   = cell_entry[0];
                head_key_next  = cell_valid[1] ? cell_entry[1].key  : 16'd0;
                head_prio_next = cell_valid[1] ? cell_entry[1].prio : 16'd0;
            end
        end
    end

    assign count_ext = {5'd0, count_next};

    // output slot handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (apply_go)
            out_valid_next = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
            if (apply_go)
                count_reg <= count_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= req.cmd;
            item_reg.key  <= req.unique_key;
            item_reg.prio <= req.priority_req;
            item_reg.tag  <= req.payload_tag;
        end
        if (apply_go)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            head_key_reg  <= head_key_next;
            head_prio_reg <= head_prio_next;
            occ_reg       <= count_ext[4:0];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.out_key       = removed_reg.key;
    assign rsp.out_priority  = removed_reg.prio;
    assign rsp.out_payload   = removed_reg.tag;
    assign rsp.head_key      = head_key_reg;
    assign rsp.head_priority = head_prio_reg;
    assign rsp.occupancy     = occ_reg;

endmodule
`default_nettype wire

FILE: tb/tb_sorted_priority_queue_unique_key_top.sv
// testbench for the sorted priority queue: directed, fill, pressure and random command streams
`default_nettype none
module tb_sorted_priority_queue_unique_key_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = spq_pkg::QUEUE_DEPTH_DEF;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_IDLE = 4000;
    localparam int SETTLE_CYCLES = DEPTH + 8;

    // one result beat as the queue should report it
    typedef struct packed {
        logic            cmd;
        logic [1:0]      status;
        spq_pkg::entry_t removed;
        logic [15:0]     head_key;
        logic [15:0]     head_prio;
        logic [4:0]      occupancy;
    } reply_t;

    logic clk;
    logic rst_n;

    spq_in_if  req_if ();
    spq_out_if rsp_if ();

    sorted_priority_queue_unique_key_top #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    // shadow copy of the sorted queue, head at index 0
    spq_pkg::entry_t shadow_entries[$];
    reply_t expected_rsp[$];

    bit quiet;
    int holds_requested;
    int error_count;
    int cmds_sent;
    int n_stored;
    int n_removed;
    int n_full;
    int n_dup;
    int n_empty;
    int peak_occupancy;

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // key lookup in the shadow queue
    function automatic bit key_held(input logic [15:0] k);
        foreach (shadow_entries[i])
        begin
            if (shadow_entries[i].key == k)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one command to the shadow queue and form the reply it must produce
    function automatic reply_t predict_reply(input logic c, input spq_pkg::entry_t e);
        reply_t r;
        int     pos;
        r = '0;
        r.cmd = c;
        if (c == spq_pkg::CMD_INSERT)
        begin
            if (shadow_entries.size() >= DEPTH)
                r.status = spq_pkg::ST_FULL;
            else if (key_held(e.key))
                r.status = spq_pkg::ST_DUP;
            else
            begin
                // goes behind every entry with equal or smaller priority
                pos = 0;
                while (pos < shadow_entries.size() && shadow_entries[pos].prio <= e.prio)
                    pos++;
                shadow_entries.insert(pos, e);
                r.status = spq_pkg::ST_OK;
            end
        end
        else
        begin
            if (shadow_entries.size() == 0)
                r.status = spq_pkg::ST_EMPTY;
            else
            begin
                r.removed = shadow_entries.pop_front();
                r.status  = spq_pkg::ST_OK;
            end
        end
        if (shadow_entries.size() > 0)
        begin
            r.head_key  = shadow_entries[0].key;
            r.head_prio = shadow_entries[0].prio;
        end
        r.occupancy = 5'(shadow_entries.size());
        return r;
    endfunction

    // key draw: small pool for collisions, held keys for duplicates, full range otherwise
    function automatic logic [15:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 16'($urandom_range(0, 23));
        else if (sel < 70 && shadow_entries.size() > 0)
            return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)].key;
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    // priority draw: narrow range for ties, the two extremes, or full range
    function automatic logic [15:0] pick_prio();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 16'($urandom_range(0, 7));
        else if (sel < 60)
            return 16'h0000;
        else if (sel < 70)
            return 16'hFFFF;
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    // present one command beat and hold it until accepted
    task automatic send_cmd(input logic c, input logic [15:0] k, input logic [15:0] p,
                            input logic [31:0] t);
        spq_pkg::entry_t e;
        e.key  = k;
        e.prio = p;
        e.tag  = t;
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.cmd          <= c;
        req_if.unique_key   <= k;
        req_if.priority_req <= p;
        req_if.payload_tag  <= t;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        expected_rsp.push_back(predict_reply(c, e));
        cmds_sent++;
    endtask

    // one remove beat with random filler in the unused fields
    task automatic send_remove();
        send_cmd(spq_pkg::CMD_REMOVE, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), $urandom);
    endtask

    // one random command, insert with the given percentage
    task automatic send_random(input int insert_pct);
        if ($urandom_range(0, 99) < insert_pct)
            send_cmd(spq_pkg::CMD_INSERT, pick_key(), pick_prio(), $urandom);
        else
            send_remove();
    endtask

    // stop offering, let every reply come back and the cell row settle
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // remove on an empty queue right after reset
    task automatic test_empty_queue();
        send_cmd(spq_pkg::CMD_REMOVE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(spq_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000);
        wait_idle();
    endtask

    // field extremes, ties on both ends, duplicates, drain past empty
    task automatic test_field_extremes();
        send_cmd(spq_pkg::CMD_INSERT, 16'h0000, 16'hFFFF, 32'h0000_0000);
        send_cmd(spq_pkg::CMD_INSERT, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        send_cmd(spq_pkg::CMD_INSERT, 16'h0001, 16'hFFFF, 32'hA5A5_5A5A);
        send_cmd(spq_pkg::CMD_INSERT, 16'hFFFF, 16'h0005, 32'h1234_5678);
        send_cmd(spq_pkg::CMD_INSERT, 16'h0000, 16'h0000, 32'h8765_4321);
        send_cmd(spq_pkg::CMD_INSERT, 16'h0002, 16'h0000, 32'h5A5A_A5A5);
        repeat (5)
            send_remove();
        wait_idle();
    endtask

    // fill to capacity, insert past full (also with a held key), drain past empty
    task automatic test_fill_and_drain();
        logic [15:0] k;
        repeat (DEPTH)
        begin
            do
                k = 16'($urandom_range(0, 65535));
            while (key_held(k));
            send_cmd(spq_pkg::CMD_INSERT, k, 16'($urandom_range(0, 3)), $urandom);
        end
        do
            k = 16'($urandom_range(0, 65535));
        while (key_held(k));
        send_cmd(spq_pkg::CMD_INSERT, k, 16'h0000, $urandom);
        send_cmd(spq_pkg::CMD_INSERT, shadow_entries[3].key, 16'h0001, $urandom);
        repeat (DEPTH + 1)
            send_remove();
        wait_idle();
    endtask

    // no idling on either side
    task automatic test_back_to_back(input int n_items);
        quiet = 1'b1;
        repeat (n_items)
            send_random(55);
        wait_idle();
        quiet = 1'b0;
    endtask

    // receiver holds off while commands keep coming
    task automatic test_result_backpressure(input int n_items);
        holds_requested++;
        repeat (n_items)
            send_random(60);
        wait_idle();
    endtask

    // phases biased toward filling, draining or balanced
    task automatic test_random_mix(input int n_items);
        int insert_pct;
        insert_pct = 50;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 25;
                    default: insert_pct = 50;
                endcase
            end
            send_random(insert_pct);
        end
        wait_idle();
    endtask

    // compare one field of a result beat
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // result sink: ready with random hold-offs and requested long stalls
    initial
    begin : result_sink
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (holds_served != holds_requested)
            begin
                holds_served++;
                stall_left = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 7);
        end
    end

    // check each result beat against the oldest expectation
    always @(posedge clk)
    begin : result_checker
        reply_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("result beat with no command outstanding");
                error_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_if.status));
                check_field("out_key", 32'(want.removed.key), 32'(rsp_if.out_key));
                check_field("out_priority", 32'(want.removed.prio),
                            32'(rsp_if.out_priority));
                check_field("out_payload", want.removed.tag, rsp_if.out_payload);
                check_field("head_key", 32'(want.head_key), 32'(rsp_if.head_key));
                check_field("head_priority", 32'(want.head_prio),
                            32'(rsp_if.head_priority));
                check_field("occupancy", 32'(want.occupancy), 32'(rsp_if.occupancy));
                case (want.status)
                    spq_pkg::ST_FULL:  n_full++;
                    spq_pkg::ST_DUP:   n_dup++;
                    spq_pkg::ST_EMPTY: n_empty++;
                    default:
                    begin
                        if (want.cmd == spq_pkg::CMD_REMOVE)
                            n_removed++;
                        else
                            n_stored++;
                    end
                endcase
                if (want.occupancy > peak_occupancy)
                    peak_occupancy = int'(want.occupancy);
            end
        end
    end

    // watchdog: too long without a beat on either channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_IDLE)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no beat for %0d cycles, %0d replies outstanding", WATCHDOG_IDLE,
               expected_rsp.size());
        $display("tb_sorted_priority_queue_unique_key_top: done, errors");
        $finish;
    end

    // main sequence
    initial
    begin
        quiet           = 1'b0;
        holds_requested = 0;
        error_count     = 0;
        cmds_sent       = 0;
        n_stored        = 0;
        n_removed       = 0;
        n_full          = 0;
        n_dup           = 0;
        n_empty         = 0;
        peak_occupancy  = 0;
        rst_n               <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.cmd          <= spq_pkg::CMD_INSERT;
        req_if.unique_key   <= '0;
        req_if.priority_req <= '0;
        req_if.payload_tag  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_field_extremes();
        test_fill_and_drain();
        test_back_to_back(60);
        test_result_backpressure(24);
        test_random_mix(780);

        if (expected_rsp.size() != 0)
        begin
            $error("%0d expected replies never arrived", expected_rsp.size());
            error_count++;
        end
        $display("covered %0d commands: %0d stored, %0d removed, %0d full, %0d dup, %0d empty",
                 cmds_sent, n_stored, n_removed, n_full, n_dup, n_empty);
        $display("peak occupancy %0d of %0d, one result hold-off of %0d cycles",
                 peak_occupancy, DEPTH, HOLD_CYCLES);
        if (error_count == 0)
            $display("tb_sorted_priority_queue_unique_key_top: done, clean");
        else
            $display("tb_sorted_priority_queue_unique_key_top: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
